### design/srlm_pkg.sv
// Shared types and constants for the stereo RMS level meter.
// No dependencies; used by srlm_ctrl, srlm_dp and stereo_rms_level_meter.
package srlm_pkg;

    // Default buffer length limit in pairs
    localparam int unsigned MAX_PAIRS_DEF = 1024;

    // Field widths
    localparam int unsigned SMP_W   = 16;   // one sample, signed Q1.15
    localparam int unsigned SQ_W    = 31;   // square of one sample
    localparam int unsigned COEF_W  = 16;   // Q16 coefficient
    localparam int unsigned RMS_W   = 15;   // RMS result
    localparam int unsigned LVL_W   = 16;   // smoothed level
    localparam int unsigned MEAN_W  = 29;   // mean square, at most 2^28
    localparam int unsigned RAD_W   = 30;   // mean square padded to even width
    localparam int unsigned SREM_W  = 17;   // root remainder
    localparam int unsigned IN_W    = 32;   // input tdata width
    localparam int unsigned OUT_W   = 32;   // output tdata width
    localparam int unsigned CIDX_W  = 8;    // configuration index width

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_DECAY = 8'd0;
    localparam logic [CIDX_W-1:0] REG_GAIN  = 8'd1;

    // Configuration reset values (0.8 and 0.5 in Q16)
    localparam logic [COEF_W-1:0] DECAY_RST = 16'd52429;
    localparam logic [COEF_W-1:0] GAIN_RST  = 16'd32768;

    // Rounding offset for the Q16 level product
    localparam logic [32:0] LVL_ROUND = 33'd32768;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // register the squares of an accepted pair
        logic acc_add;     // add the squares into the running sum
        logic div_init;    // load divider, clear sum and count
        logic div_step;    // one quotient bit
        logic sqrt_init;   // load root unit from the quotient
        logic sqrt_step;   // one root bit
        logic mul;         // form both level products
        logic level;       // update level and load the output register
    } t_cmd;

endpackage

### design/stereo_rms_level_meter.sv
// Top level of the stereo RMS level meter.
// Depends on srlm_pkg, srlm_ctrl and srlm_dp.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid/tready       | tdata: left, right; tlast: end
//  m_axis    | out       | m_axis_tvalid/tready       | tdata: rms_value, smoothed_level
//  cfg       | in        | i_cfg_valid/o_cfg_ready    | i_cfg_index, i_cfg_data
//
// A pair without tlast is accepted, then its squares are added.
// A pair with tlast is accepted and added, then passes the serial divider
// (SUM_W - 3 quotient bits, SUM_W = 32 + clog2(MAX_PAIRS)), the 15-step
// root unit and the level update. A new pair is taken while a result waits
// in the output register; a second result holds in the level stage until it frees.
// Reset is synchronous and active low and clears sum, count and level.
module stereo_rms_level_meter #(
    parameter int unsigned MAX_PAIRS = srlm_pkg::MAX_PAIRS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] left_sample, [31:16] right_sample
    input  logic [srlm_pkg::IN_W-1:0]         s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [14:0] rms_value, [30:15] smoothed_level, [31] zero
    output logic [srlm_pkg::OUT_W-1:0]        m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [srlm_pkg::CIDX_W-1:0]       i_cfg_index,
    input  logic [srlm_pkg::COEF_W-1:0]       i_cfg_data
);

    srlm_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    srlm_ctrl #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    srlm_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_left      (s_axis_tdata[15:0]),
        .i_right     (s_axis_tdata[31:16]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (m_axis_tdata)
    );

endmodule

### design/srlm_ctrl.sv
// Controller state machine of the stereo RMS level meter.
// Depends on srlm_pkg; drives srlm_dp through a t_cmd command struct.
module srlm_ctrl #(
    parameter int unsigned MAX_PAIRS = srlm_pkg::MAX_PAIRS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output srlm_pkg::t_cmd o_cmd
);

    localparam int unsigned SUM_W  = 32 + $clog2(MAX_PAIRS);
    localparam int unsigned DIV_W  = SUM_W - 3;
    localparam int unsigned STEP_W = $clog2(DIV_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DINIT,
        S_DIV,
        S_SINIT,
        S_SQRT,
        S_MUL,
        S_LVL
    } t_state;

    t_state              r_state, n_state;
    logic                r_last, n_last;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                w_load;

    // Output register free or being emptied this cycle
    assign w_load = (r_state == S_LVL) && (!r_out_valid || i_out_ready);

    // Commands decoded from the state
    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.acc_add   = (r_state == S_ACC);
        o_cmd.div_init  = (r_state == S_DINIT);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.sqrt_init = (r_state == S_SINIT);
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.level     = w_load;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state, step counter and output valid
    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last  = i_in_last;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = r_last ? S_DINIT : S_IDLE;
            end
            S_DINIT: begin
                n_step  = STEP_W'(DIV_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_step == '0) begin
                    n_state = S_SINIT;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_SINIT: begin
                n_step  = STEP_W'(srlm_pkg::RMS_W - 1);
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_step == '0) begin
                    n_state = S_MUL;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_MUL: begin
                n_state = S_LVL;
            end
            S_LVL: begin
                // hold until the output register can take the result
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### design/srlm_dp.sv
// Datapath of the stereo RMS level meter: squares, running sum, serial
// divider, serial square root, level update and coefficient registers.
// Depends on srlm_pkg; commanded by srlm_ctrl.
module srlm_dp #(
    parameter int unsigned MAX_PAIRS = srlm_pkg::MAX_PAIRS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  srlm_pkg::t_cmd                     i_cmd,
    input  logic signed [srlm_pkg::SMP_W-1:0]  i_left,
    input  logic signed [srlm_pkg::SMP_W-1:0]  i_right,
    input  logic                               i_cfg_valid,
    input  logic [srlm_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [srlm_pkg::COEF_W-1:0]        i_cfg_data,
    output logic [srlm_pkg::OUT_W-1:0]         o_out_data
);

    localparam int unsigned CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int unsigned SUM_W = 32 + $clog2(MAX_PAIRS);
    localparam int unsigned DIV_W = SUM_W - 3;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAIRS);

    localparam int unsigned SQ_W   = srlm_pkg::SQ_W;
    localparam int unsigned RMS_W  = srlm_pkg::RMS_W;
    localparam int unsigned LVL_W  = srlm_pkg::LVL_W;
    localparam int unsigned COEF_W = srlm_pkg::COEF_W;
    localparam int unsigned RAD_W  = srlm_pkg::RAD_W;
    localparam int unsigned MEAN_W = srlm_pkg::MEAN_W;
    localparam int unsigned SREM_W = srlm_pkg::SREM_W;

    logic signed [31:0]  w_ext_l, w_ext_r, w_prod_l, w_prod_r;
    logic [SQ_W-1:0]     r_sq_l, r_sq_r;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIV_W-1:0]    r_div;
    logic [CNT_W-1:0]    r_rem, r_dvs;
    logic [CNT_W:0]      w_rem_sh, w_rem_sub;
    logic                w_div_ge;
    logic [RAD_W-1:0]    r_rad;
    logic [SREM_W-1:0]   r_srem;
    logic [RMS_W-1:0]    r_root;
    logic [SREM_W+1:0]   w_srem_sh, w_trial, w_srem_sub;
    logic                w_sqrt_ge;
    logic [COEF_W-1:0]   r_decay, r_gain;
    logic [LVL_W-1:0]    r_level;
    logic [31:0]         r_p_lvl;
    logic [30:0]         r_p_rms;
    logic [32:0]         w_lsum;
    logic [LVL_W-1:0]    w_lev_sat;
    logic [srlm_pkg::OUT_W-1:0] r_out_data;

    // Square both samples of the pair
    assign w_ext_l  = 32'(i_left);
    assign w_ext_r  = 32'(i_right);
    assign w_prod_l = w_ext_l * w_ext_l;
    assign w_prod_r = w_ext_r * w_ext_r;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sq_l <= w_prod_l[SQ_W-1:0];
            r_sq_r <= w_prod_r[SQ_W-1:0];
        end
    end

    // Accumulate until the pair limit, clear when the divider loads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_init) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc_add && (r_cnt < CNT_MAX)) begin
            r_sum <= r_sum + SUM_W'(r_sq_l) + SUM_W'(r_sq_r);
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Restoring divider: (sum / 8) / count, one quotient bit per cycle
    assign w_rem_sh  = {r_rem, r_div[DIV_W-1]};
    assign w_div_ge  = (w_rem_sh >= {1'b0, r_dvs});
    assign w_rem_sub = w_rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_div <= r_sum[SUM_W-1:3];
            r_rem <= '0;
            r_dvs <= r_cnt;
        end else if (i_cmd.div_step) begin
            if (w_div_ge) begin
                r_rem <= w_rem_sub[CNT_W-1:0];
                r_div <= {r_div[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[CNT_W-1:0];
                r_div <= {r_div[DIV_W-2:0], 1'b0};
            end
        end
    end

    // Digit-by-digit square root, two radicand bits per cycle
    assign w_srem_sh  = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign w_trial    = (SREM_W + 2)'({r_root, 2'b01});
    assign w_sqrt_ge  = (w_srem_sh >= w_trial);
    assign w_srem_sub = w_srem_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_rad  <= {1'b0, r_div[MEAN_W-1:0]};
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (w_sqrt_ge) begin
                r_srem <= w_srem_sub[SREM_W-1:0];
                r_root <= {r_root[RMS_W-2:0], 1'b1};
            end else begin
                r_srem <= w_srem_sh[SREM_W-1:0];
                r_root <= {r_root[RMS_W-2:0], 1'b0};
            end
        end
    end

    // Coefficient registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= srlm_pkg::DECAY_RST;
            r_gain  <= srlm_pkg::GAIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                srlm_pkg::REG_DECAY: r_decay <= i_cfg_data;
                srlm_pkg::REG_GAIN:  r_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Level products
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p_lvl <= 32'(r_level) * 32'(r_decay);
            r_p_rms <= 31'(r_root) * 31'(r_gain);
        end
    end

    // Round, scale and saturate the level
    assign w_lsum    = 33'(r_p_lvl) + 33'(r_p_rms) + srlm_pkg::LVL_ROUND;
    assign w_lev_sat = w_lsum[32] ? {LVL_W{1'b1}} : w_lsum[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cmd.level) begin
            r_level <= w_lev_sat;
        end
    end

    // Output register: rms in the low bits, level above, zero pad on top
    always_ff @(posedge i_clk) begin
        if (i_cmd.level) begin
            r_out_data <= {1'b0, w_lev_sat, r_root};
        end
    end

    assign o_out_data = r_out_data;

endmodule
